### rtl/mllp_pkg.sv
// shared types and constants for the mllp frame receiver
// no dependencies; imported by mllp_front, mllp_back and mllp_frame_receiver

package mllp_pkg;

  localparam int BUFFER_DEPTH = 1024;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int LEN_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int TICK_W       = 32;
  localparam int BYTE_W       = 8;
  localparam int RIDX_W       = 10;

  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_POLL = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [BYTE_W-1:0] BYTE_VT = 8'h0B;
  localparam logic [BYTE_W-1:0] BYTE_FS = 8'h1C;
  localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd1000;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_VT,
    OP_FS,
    OP_CR,
    OP_DATA,
    OP_POLL,
    OP_READ
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_IN_FRAME = 2'd1,
    ST_GOT_FS   = 2'd2
  } framer_state_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
    logic [TICK_W-1:0] tick;
    logic [RIDX_W-1:0] ridx;
  } cmd_t;

  typedef struct packed {
    logic              done;
    logic [LEN_W-1:0]  len;
    logic              err;
    logic              busy;
    logic              tmo;
    logic              sv;
    logic [ADDR_W-1:0] sidx;
    logic              rd_hit;
  } res_t;

endpackage

### rtl/mllp_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module mllp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/mllp_front.sv
// front end: accepts input transactions, classifies them, queues up to two commands
// depends on mllp_pkg

module mllp_front import mllp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic [TICK_W-1:0] in_tick,
  input  logic [RIDX_W-1:0] in_ridx,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output cmd_t              cmd
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       cls;

  always_comb begin
    cls.data = in_byte;
    cls.tick = in_tick;
    cls.ridx = in_ridx;
    unique case (in_mode)
      MODE_BYTE: begin
        if (in_byte == BYTE_VT) begin
          cls.op = OP_VT;
        end else if (in_byte == BYTE_FS) begin
          cls.op = OP_FS;
        end else if (in_byte == BYTE_CR) begin
          cls.op = OP_CR;
        end else begin
          cls.op = OP_DATA;
        end
      end
      MODE_POLL: cls.op = OP_POLL;
      MODE_READ: cls.op = OP_READ;
      default:   cls.op = OP_NOP;
    endcase
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rd_ptr_r];

  assign wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
  assign rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
  assign cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### rtl/mllp_back.sv
// back end: framer state machine, payload buffer and result register
// depends on mllp_pkg and mllp_ram

module mllp_back import mllp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_timeout,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res,
  output logic [BYTE_W-1:0] res_rdata
);

  framer_state_t     state_r, state_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [TICK_W-1:0] open_tick_r, open_tick_nxt;
  logic              err_r, err_nxt;
  logic [TICK_W-1:0] timeout_r;
  logic              res_valid_r;
  res_t              res_r, res_nxt;

  logic              fire;
  logic              is_byte;
  logic              room;
  logic              timeout_hit;
  logic [TICK_W-1:0] age;
  logic              we, re;
  logic [BYTE_W-1:0] ram_rdata;

  assign cmd_ready   = !res_valid_r || res_ready;
  assign fire        = cmd_valid && cmd_ready;
  assign is_byte     = (cmd.op == OP_VT) || (cmd.op == OP_FS) ||
                       (cmd.op == OP_CR) || (cmd.op == OP_DATA);
  assign room        = (32'(len_r) < BUFFER_DEPTH);
  assign age         = cmd.tick - open_tick_r;
  assign timeout_hit = (state_r != ST_IDLE) && (age > timeout_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    if (is_byte) begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.op == OP_VT) begin
            state_nxt = ST_IN_FRAME;
          end
        end
        ST_IN_FRAME: begin
          if (cmd.op == OP_FS) begin
            state_nxt = ST_GOT_FS;
          end
        end
        ST_GOT_FS: state_nxt = ST_IDLE;
        default:   state_nxt = ST_IDLE;
      endcase
    end else if (cmd.op == OP_POLL && timeout_hit) begin
      state_nxt = ST_IDLE;
    end
  end

  // datapath and per-transaction flags
  always_comb begin
    len_nxt       = len_r;
    err_nxt       = err_r;
    open_tick_nxt = open_tick_r;
    we            = 1'b0;
    re            = 1'b0;
    res_nxt.done   = 1'b0;
    res_nxt.tmo    = 1'b0;
    res_nxt.sv     = 1'b0;
    res_nxt.sidx   = '0;
    res_nxt.rd_hit = 1'b0;
    if (is_byte) begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.op == OP_VT) begin
            len_nxt       = '0;
            err_nxt       = 1'b0;
            open_tick_nxt = cmd.tick;
          end
        end
        ST_IN_FRAME: begin
          if (cmd.op == OP_VT) begin
            len_nxt       = '0;
            err_nxt       = 1'b1;
            open_tick_nxt = cmd.tick;
          end else if (cmd.op == OP_FS) begin
            len_nxt = len_r;
          end else if (room) begin
            we           = 1'b1;
            res_nxt.sv   = 1'b1;
            res_nxt.sidx = len_r[ADDR_W-1:0];
            len_nxt      = len_r + 1'b1;
          end else begin
            err_nxt = 1'b1;
          end
        end
        ST_GOT_FS: begin
          if (cmd.op == OP_CR) begin
            res_nxt.done = 1'b1;
          end else begin
            len_nxt = '0;
            err_nxt = 1'b1;
          end
        end
        default: len_nxt = '0;
      endcase
    end else if (cmd.op == OP_POLL) begin
      if (timeout_hit) begin
        len_nxt     = '0;
        err_nxt     = 1'b1;
        res_nxt.tmo = 1'b1;
      end
    end else if (cmd.op == OP_READ) begin
      if (32'(cmd.ridx) < BUFFER_DEPTH) begin
        re             = 1'b1;
        res_nxt.rd_hit = 1'b1;
      end
    end
    res_nxt.len  = len_nxt;
    res_nxt.err  = err_nxt;
    res_nxt.busy = (state_nxt != ST_IDLE);
  end

  mllp_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(BUFFER_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (fire && we),
    .waddr(len_r[ADDR_W-1:0]),
    .wdata(cmd.data),
    .re   (fire && re),
    .raddr(cmd.ridx[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      open_tick_r <= '0;
      err_r       <= 1'b0;
      timeout_r   <= TIMEOUT_RESET;
      res_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_timeout;
      end
      if (fire) begin
        state_r     <= state_nxt;
        len_r       <= len_nxt;
        open_tick_r <= open_tick_nxt;
        err_r       <= err_nxt;
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign res_rdata = res_r.rd_hit ? ram_rdata : '0;

endmodule

### rtl/mllp_frame_receiver.sv
// top level of the mllp frame receiver
// depends on mllp_pkg, mllp_front, mllp_back (and mllp_ram through mllp_back)

// Receive-side MLLP framer. Every input transaction is a received byte, a
// timeout poll or a buffer read (in_tuser selects), and yields exactly one
// result transaction. VT opens a frame, payload bytes are written to a
// 1024-byte buffer, FS then CR closes it; out_tlast marks the closing CR.
// Throughput is one transaction per clock while out_tready holds no result
// back: the framer state update and the buffer write or read are done in
// the same cycle of the back end. An accepted input is first written to a
// queue entry; when the framer takes it, it loads the result register and
// the registered buffer read, and out_tvalid rises. A two-entry queue
// decouples the input from the framer, so up to two more transactions are
// accepted while a result waits. The buffer is not cleared at reset; read
// only entries written since reset. Write the timeout register only while
// no transaction is in flight.

module mllp_frame_receiver import mllp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,     // timeout_ticks
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,     // data_byte[7:0], current_tick[39:8], read_index[49:40]
  input  logic [1:0]  in_tuser,     // mode
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,    // frame_length[10:0], frame_error[11], busy_res[12],
                                    // timed_out[13], stored_valid[14],
                                    // stored_index[24:15], read_data[32:25]
  output logic        out_tlast     // frame_done
);

  logic              cmd_valid;
  logic              cmd_ready;
  cmd_t              cmd;
  res_t              res;
  logic [BYTE_W-1:0] res_rdata;

  assign cfg_ready = 1'b1;

  mllp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_mode  (in_tuser),
    .in_byte  (in_tdata[7:0]),
    .in_tick  (in_tdata[39:8]),
    .in_ridx  (in_tdata[49:40]),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  mllp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_timeout(cfg_data),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res),
    .res_rdata  (res_rdata)
  );

  assign out_tlast = res.done;
  assign out_tdata = {7'b0, res_rdata, res.sidx, res.sv, res.tmo, res.busy, res.err,
                      res.len};

  a_store_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.sv |-> res.busy && !res.done && !res.tmo
      && ({1'b0, res.sidx} + 1'b1 == res.len))
    else $error("stored byte does not match frame length");

  a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.tmo |-> !res.busy && res.err && (res.len == '0))
    else $error("timeout left frame open");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.done |-> !res.busy && !res.sv)
    else $error("frame completion with framer busy");

  a_no_len_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(res.len) <= BUFFER_DEPTH))
    else $error("frame length beyond buffer depth");

endmodule
